### rtl/core/gcrl_pkg.sv
// ----------------------------------------------------------------------------
// Gradient colour ramp package
// Shared constants, codes and types for the colour ramp lookup block.
// ----------------------------------------------------------------------------
package gcrl_pkg;

   localparam int MAX_STOPS_DEFAULT     = 16;
   localparam int POS_FRAC_BITS_DEFAULT = 16;
   localparam int POS_WIDTH             = 24;
   localparam int COLOR_WIDTH           = 32;

   localparam logic [1:0] MODE_LOOKUP = 2'd0;
   localparam logic [1:0] MODE_ADD    = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;
   localparam logic [1:0] MODE_NONE   = 2'd3;

   localparam logic [1:0] EXT_PAD     = 2'd0;
   localparam logic [1:0] EXT_REPEAT  = 2'd1;
   localparam logic [1:0] EXT_REFLECT = 2'd2;
   localparam logic [1:0] EXT_SPARE   = 2'd3;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic [31:0] COLOR_BLACK = 32'h0000_00FF;
   localparam logic [31:0] COLOR_WHITE = 32'hFFFF_FFFF;

   // Handshake between the sequencer and the shared divider.
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctrl_type;

endpackage

### rtl/core/gradient_color_ramp_lookup_top.sv
// A clear, a rejected add or an unused mode gives its result in the cycle after acceptance;
// an accepted add searches and then shifts the table one entry per cycle. A lookup searches
// the table and, when the key lies between two stops or the table is empty, interpolates
// with four divisions on the shared divider, one per colour channel. One transaction at a
// time; req_tready returns the cycle after the result is taken. Reset restores the
// two-stop table.
// ----------------------------------------------------------------------------
// Gradient colour ramp lookup
// Sorted colour stop table with pad, repeat and reflect position folding.
// ----------------------------------------------------------------------------
module gradient_color_ramp_lookup_top #(
   parameter int MAX_STOPS     = gcrl_pkg::MAX_STOPS_DEFAULT,
   parameter int POS_FRAC_BITS = gcrl_pkg::POS_FRAC_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] mode, [25:2] position, [57:26] stop_color, [63:58] zero
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] result_color, [33:32] status, [38:34] stops_held, [39] zero
   output logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data
);

   localparam int PW  = POS_FRAC_BITS + 1;
   localparam int IW  = $clog2(MAX_STOPS);
   localparam int CW  = $clog2(MAX_STOPS + 1);
   localparam int NW  = PW + 9;
   localparam logic [PW-1:0] POS_ONE = PW'(1) << POS_FRAC_BITS;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEARCH, ST_SHIFT, ST_DIV, ST_WAIT, ST_OUT
   } state_type;

   state_type           state_ff;
   logic [1:0]          ext_ff;
   logic [CW-1:0]       count_ff;
   logic [PW-1:0]       pos_mem [MAX_STOPS];
   logic [31:0]         col_mem [MAX_STOPS];
   logic [1:0]          mode_ff;
   logic [PW-1:0]       key_ff;
   logic [31:0]         cin_ff;
   logic [CW-1:0]       idx_ff;
   logic [31:0]         res_ff;
   logic [1:0]          status_ff;
   logic [1:0]          chan_ff;
   logic [31:0]         left_ff, right_ff;
   logic [PW-1:0]       a_ff, d_ff;
   logic [NW-1:0]       num_ff;
   logic                div_start_ff;
   logic [NW-1:0]       quotient;
   gcrl_pkg::div_ctrl_type div_ctrl;

   logic [1:0]          in_mode;
   logic signed [23:0]  in_pos;
   logic                neg;
   logic [PW-1:0]       frac, folded, in_key;
   logic                odd, big;
   logic [IW-1:0]       idx_lo, idx_prev, cnt_last;
   logic [PW-1:0]       pos_at;
   logic [7:0]          cl, cr;
   logic [2*PW+8:0]     prod_sum;

   assign in_mode = req_tdata[1:0];
   assign in_pos  = req_tdata[25:2];
   assign neg     = in_pos[23];
   assign frac    = {1'b0, in_pos[POS_FRAC_BITS-1:0]};
   assign odd     = in_pos[POS_FRAC_BITS];
   assign big     = !neg && (25'(unsigned'(in_pos)) > 25'(POS_ONE));

   always_comb begin
      case (ext_ff)
         gcrl_pkg::EXT_REPEAT:  folded = frac;
         gcrl_pkg::EXT_REFLECT: folded = odd ? POS_ONE - frac : frac;
         default:               folded = neg ? '0 : (big ? POS_ONE : in_pos[PW-1:0]);
      endcase
      in_key = (in_mode == gcrl_pkg::MODE_LOOKUP) ? folded : in_pos[PW-1:0];
   end

   assign idx_lo   = idx_ff[IW-1:0];
   assign idx_prev = IW'(idx_ff - 1'b1);
   assign cnt_last = IW'(count_ff - 1'b1);
   assign pos_at   = pos_mem[idx_lo];

   always_comb begin
      cl = left_ff[8*chan_ff +: 8];
      cr = right_ff[8*chan_ff +: 8];
   end
   // One channel numerator per division; narrow multiplies, registered before use.
   assign prod_sum = (2*PW+9)'(cl) * (2*PW+9)'(d_ff - a_ff)
                   + (2*PW+9)'(cr) * (2*PW+9)'(a_ff) + (2*PW+9)'(d_ff >> 1);

   gcrl_divider #(.NUM_WIDTH(NW), .DEN_WIDTH(PW)) u_div (
      .clock(clock), .reset(reset), .start(div_start_ff),
      .numerator(num_ff), .denominator(d_ff), .ctrl(div_ctrl), .quotient(quotient)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {1'b0, 5'(count_ff), status_ff, res_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ext_ff    <= gcrl_pkg::EXT_PAD;
         count_ff  <= CW'(2);
         div_start_ff <= 1'b0;
         pos_mem[0] <= '0;
         pos_mem[1] <= POS_ONE;
         col_mem[0] <= gcrl_pkg::COLOR_BLACK;
         col_mem[1] <= gcrl_pkg::COLOR_WHITE;
      end else begin
         if (csr_valid) ext_ff <= csr_data;
         div_start_ff <= (state_ff == ST_DIV) && (d_ff != '0);
         case (state_ff)
            ST_IDLE: if (req_tvalid) begin
               mode_ff   <= in_mode;
               key_ff    <= in_key;
               cin_ff    <= req_tdata[57:26];
               res_ff    <= '0;
               status_ff <= gcrl_pkg::STATUS_DONE;
               idx_ff    <= '0;
               chan_ff   <= '0;
               state_ff  <= ST_OUT;
               case (in_mode)
                  gcrl_pkg::MODE_LOOKUP: begin
                     if (count_ff == '0) begin
                        left_ff  <= gcrl_pkg::COLOR_BLACK;
                        right_ff <= gcrl_pkg::COLOR_WHITE;
                        a_ff     <= in_key;
                        d_ff     <= POS_ONE;
                        state_ff <= ST_DIV;
                     end else state_ff <= ST_SEARCH;
                  end
                  gcrl_pkg::MODE_ADD: begin
                     if (neg || big) status_ff <= gcrl_pkg::STATUS_RANGE;
                     else if (count_ff >= CW'(MAX_STOPS))
                        status_ff <= gcrl_pkg::STATUS_FULL;
                     else state_ff <= ST_SEARCH;
                  end
                  gcrl_pkg::MODE_CLEAR: count_ff <= '0;
                  default: ;
               endcase
            end
            ST_SEARCH: begin
               if (mode_ff == gcrl_pkg::MODE_ADD) begin
                  if (idx_ff < count_ff && pos_at < key_ff) idx_ff <= idx_ff + 1'b1;
                  else begin
                     idx_ff   <= count_ff;
                     a_ff     <= PW'(idx_ff); // insertion point held here
                     state_ff <= ST_SHIFT;
                  end
               end else if (idx_ff == '0) begin
                  if (count_ff == CW'(1) || key_ff <= pos_at) begin
                     res_ff   <= col_mem[0];
                     state_ff <= ST_OUT;
                  end else idx_ff <= CW'(1);
               end else if (key_ff >= pos_mem[cnt_last]) begin
                  res_ff   <= col_mem[cnt_last];
                  state_ff <= ST_OUT;
               end else if (pos_at > key_ff) begin
                  left_ff  <= col_mem[idx_prev];
                  right_ff <= col_mem[idx_lo];
                  a_ff     <= key_ff - pos_mem[idx_prev];
                  d_ff     <= pos_at - pos_mem[idx_prev];
                  state_ff <= ST_DIV;
               end else idx_ff <= idx_ff + 1'b1;
            end
            ST_SHIFT: begin
               if (idx_ff > CW'(a_ff)) begin
                  pos_mem[idx_lo] <= pos_mem[idx_prev];
                  col_mem[idx_lo] <= col_mem[idx_prev];
                  idx_ff <= idx_ff - 1'b1;
               end else begin
                  pos_mem[idx_lo] <= key_ff;
                  col_mem[idx_lo] <= cin_ff;
                  count_ff <= count_ff + 1'b1;
                  state_ff <= ST_OUT;
               end
            end
            ST_DIV: begin
               if (d_ff == '0) begin
                  res_ff   <= left_ff;
                  state_ff <= ST_OUT;
               end else begin
                  num_ff    <= NW'(prod_sum);
                  state_ff  <= ST_WAIT;
               end
            end
            ST_WAIT: if (div_ctrl.done) begin
               res_ff[8*chan_ff +: 8] <= quotient[7:0];
               chan_ff <= chan_ff + 1'b1;
               state_ff <= (chan_ff == 2'd3) ? ST_OUT : ST_DIV;
            end
            ST_OUT: if (rsp_tready) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accepting while result pending");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_STOPS)) else $error("stop count overflow");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");
   a_wait_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WAIT && !div_ctrl.done |-> div_ctrl.busy || div_start_ff)
      else $error("waiting on idle divider");

endmodule

### rtl/core/gcrl_divider.sv
// ----------------------------------------------------------------------------
// Colour ramp divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gcrl_divider #(
   parameter int NUM_WIDTH = 32,
   parameter int DEN_WIDTH = 17
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_WIDTH-1:0] numerator,
   input  logic [DEN_WIDTH-1:0] denominator,
   output gcrl_pkg::div_ctrl_type ctrl,
   output logic [NUM_WIDTH-1:0] quotient
);

   localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);

   logic [NUM_WIDTH-1:0] quo_ff, quo_in;
   logic [DEN_WIDTH:0]   rem_ff, rem_in;
   logic [DEN_WIDTH-1:0] den_ff, den_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DEN_WIDTH:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DEN_WIDTH-1:0], quo_ff[NUM_WIDTH-1]};
      if (start) begin
         quo_in  = numerator;
         rem_in  = '0;
         den_in  = denominator;
         cnt_in  = CNT_WIDTH'(NUM_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[NUM_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NUM_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign ctrl.start = start;
   assign ctrl.busy  = busy_ff;
   assign ctrl.done  = done_ff;
   assign quotient   = quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without busy");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("divider restarted while busy");
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Colour ramp lookup regression bench
// Drives stop adds, clears, lookups and unused modes with random idling on both streams,
// predicts every response from a private copy of the stop table and checks
// each response field by field.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSTOPS   = 16;
   localparam int ONE      = 65536;
   localparam int WD_LIMIT = 20000;

   typedef struct packed {
      logic [31:0] color;
      logic [1:0]  status;
      logic [4:0]  held;
   } ramp_rsp_type;

   class ramp_scoreboard_type;
      logic [16:0]  positions[NSTOPS];
      logic [31:0]  colors[NSTOPS];
      int           count;
      logic [1:0]   extend;
      ramp_rsp_type pending[$];
      int           errors;
      int           checked;

      function void clear_state();
         positions[0] = 0;
         colors[0] = gcrl_pkg::COLOR_BLACK;
         positions[1] = ONE;
         colors[1] = gcrl_pkg::COLOR_WHITE;
         count = 2;
         extend = gcrl_pkg::EXT_PAD;
         errors = 0;
         checked = 0;
      endfunction

      function logic [31:0] mix(logic [31:0] lc, logic [31:0] rc,
                                longint a, longint d);
         logic [31:0] r;
         longint ch;
         r = 0;
         if (d == 0) return lc;
         if (a > d) a = d;
         for (int sh = 0; sh < 32; sh += 8) begin
            ch = (longint'(lc[sh+:8]) * (d - a) + longint'(rc[sh+:8]) * a + d / 2) / d;
            r[sh+:8] = ch[7:0];
         end
         return r;
      endfunction

      function longint fold(logic signed [23:0] p);
         longint sx;
         longint frac;
         sx = p;
         frac = sx & (ONE - 1);
         if (extend == gcrl_pkg::EXT_REPEAT) return frac;
         if (extend == gcrl_pkg::EXT_REFLECT) return sx[16] ? ONE - frac : frac;
         if (sx < 0) return 0;
         return (sx > ONE) ? ONE : sx;
      endfunction

      function logic [31:0] colour_at(longint pos);
         int i;
         if (count == 0)
            return mix(gcrl_pkg::COLOR_BLACK, gcrl_pkg::COLOR_WHITE, pos, ONE);
         if (count == 1 || pos <= positions[0]) return colors[0];
         if (pos >= positions[count-1]) return colors[count-1];
         for (i = 0; i + 2 < count; i++)
            if (positions[i+1] > pos) break;
         return mix(colors[i], colors[i+1], pos - positions[i],
                    positions[i+1] - positions[i]);
      endfunction

      function void note_request(logic [1:0] op, logic signed [23:0] p,
                                 logic [31:0] c);
         ramp_rsp_type e;
         int at;
         longint sx;
         e = '0;
         sx = p;
         if (op == gcrl_pkg::MODE_LOOKUP) begin
            e.color = colour_at(fold(p));
         end else if (op == gcrl_pkg::MODE_ADD) begin
            if (sx < 0 || sx > ONE) begin
               e.status = gcrl_pkg::STATUS_RANGE;
            end else if (count >= NSTOPS) begin
               e.status = gcrl_pkg::STATUS_FULL;
            end else begin
               at = 0;
               while (at < count && positions[at] < sx) at++;
               for (int j = count; j > at; j--) begin
                  positions[j] = positions[j-1];
                  colors[j] = colors[j-1];
               end
               positions[at] = sx[16:0];
               colors[at] = c;
               count++;
            end
         end else if (op == gcrl_pkg::MODE_CLEAR) begin
            count = 0;
         end
         e.held = count[4:0];
         pending.insert(pending.size(), e);
      endfunction

      function void check_response(logic [39:0] d);
         ramp_rsp_type e;
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: response %h with none expected", $time, d);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (d[31:0] !== e.color) begin
            $display("%0t: colour expected %h actual %h", $time, e.color, d[31:0]);
            errors++;
         end
         if (d[33:32] !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, d[33:32]);
            errors++;
         end
         if (d[38:34] !== e.held) begin
            $display("%0t: stops expected %0d actual %0d", $time, e.held, d[38:34]);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_data;

   ramp_scoreboard_type board;
   bit  calm;
   int  quiet_cycles;

   gradient_color_ramp_lookup_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Response side: random back-pressure unless in the calm stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
         rsp_tready <= calm || ($urandom_range(99) >= 18);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
         $display("watchdog expired with %0d responses outstanding",
                  board.pending.size());
         $display("gradient_color_ramp_lookup_top regression: fail");
         $finish;
      end
   end

   // The request stays valid after acceptance until the next idle cycle or
   // the next transaction replaces it, so valid is written once per edge.
   task automatic send_item(logic [1:0] op, logic [23:0] p, logic [31:0] c);
      while (!calm && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, c, p, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(op, p, c);
   endtask

   task automatic write_extend(logic [1:0] v);
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      board.extend = v;
   endtask

   function automatic logic [23:0] pick_position();
      case ($urandom_range(5))
         0: return 24'($urandom_range(ONE));
         1: return 24'($urandom_range(4 * ONE)) - 24'(2 * ONE);
         2: return 24'($urandom());
         3: return 24'($urandom_range(8) * ONE) - 24'(4 * ONE);
         default: return 24'($urandom_range(ONE));
      endcase
   endfunction

   task automatic random_phase(int n);
      int r;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(99);
         if (r < 45) send_item(gcrl_pkg::MODE_LOOKUP, pick_position(), $urandom());
         else if (r < 85) send_item(gcrl_pkg::MODE_ADD, pick_position(), $urandom());
         else if (r < 93) send_item(gcrl_pkg::MODE_CLEAR, 24'($urandom()), $urandom());
         else send_item(gcrl_pkg::MODE_NONE, 24'($urandom()), $urandom());
      end
   endtask

   initial begin
      board = new();
      board.clear_state();
      calm = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      quiet_cycles = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset table, edges, range rejects, full table, empty ramp.
      send_item(gcrl_pkg::MODE_LOOKUP, 24'h008000, 32'd0);
      send_item(gcrl_pkg::MODE_LOOKUP, 24'h7FFFFF, 32'd0);
      send_item(gcrl_pkg::MODE_LOOKUP, 24'h800000, 32'd0);
      send_item(gcrl_pkg::MODE_ADD, 24'hFFFFFF, 32'h12345678);
      send_item(gcrl_pkg::MODE_ADD, 24'h010001, 32'h12345678);
      send_item(gcrl_pkg::MODE_ADD, 24'h008000, 32'hFF00FF00);
      send_item(gcrl_pkg::MODE_ADD, 24'h008000, 32'h00FF00FF);
      send_item(gcrl_pkg::MODE_LOOKUP, 24'h008000, 32'd0);
      send_item(gcrl_pkg::MODE_LOOKUP, 24'h004000, 32'd0);
      for (int k = 0; k < 13; k++)
         send_item(gcrl_pkg::MODE_ADD, 24'($urandom_range(ONE)), $urandom());
      send_item(gcrl_pkg::MODE_NONE, 24'hFFFFFF, 32'hFFFFFFFF);
      send_item(gcrl_pkg::MODE_CLEAR, 24'd0, 32'd0);
      send_item(gcrl_pkg::MODE_LOOKUP, 24'h00C000, 32'd0);
      send_item(gcrl_pkg::MODE_ADD, 24'h010000, 32'hA0B0C0D0);
      send_item(gcrl_pkg::MODE_LOOKUP, 24'h000000, 32'd0);

      write_extend(gcrl_pkg::EXT_REFLECT);
      send_item(gcrl_pkg::MODE_CLEAR, 24'd0, 32'd0);
      send_item(gcrl_pkg::MODE_LOOKUP, 24'h030000, 32'd0);
      send_item(gcrl_pkg::MODE_LOOKUP, 24'hFD4000, 32'd0);
      random_phase(200);
      write_extend(gcrl_pkg::EXT_REPEAT);
      random_phase(200);
      calm = 1'b1;
      random_phase(150);
      calm = 1'b0;
      write_extend(gcrl_pkg::EXT_SPARE);
      random_phase(200);
      write_extend(gcrl_pkg::EXT_PAD);
      random_phase(200);
      write_extend(gcrl_pkg::EXT_REFLECT);
      random_phase(200);

      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Covered %0d responses over pad, repeat, reflect and the spare extend code,",
               board.checked);
      $display("with stop adds, range and full rejects, clears and idle modes.");
      if (board.errors == 0)
         $display("gradient_color_ramp_lookup_top regression: pass");
      else
         $display("gradient_color_ramp_lookup_top regression: fail");
      $finish;
   end
endmodule

### filelist.f
rtl/core/gcrl_pkg.sv
rtl/core/gcrl_divider.sv
rtl/core/gradient_color_ramp_lookup_top.sv
tb/sv/testbench.sv
